/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the filter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, idle during reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Expression that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`endif

/* rtl/tmwf_pkg.sv */
// ----------------------------------------------------------------------------
// tmwf_pkg
// Shared widths, defaults and register indexes of the trimmed mean filter.
// ----------------------------------------------------------------------------
package tmwf_pkg;

	localparam int DEPTH_DEF  = 64;
	localparam int SAMPLE_W   = 16;
	localparam int WL_W       = 7;
	localparam int TRIM_W     = 6;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 7;
	localparam int WIN_DEF_RAW = 16;
	localparam int TRIM_DEF   = 2;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TRIM   = CFG_IDX_W'(1);

endpackage

/* rtl/trimmed_mean_window_filter.sv */
// One request at a time: n = min(fill, window_length) samples are read from the ring
// (one word per cycle), put through an n-pass odd-even sort, summed and divided by a
// bit-serial divider with ACC_W = 16 + bits(DEPTH); a fully trimmed window skips
// straight to the result.
// Reset clears the pointers, fill count and handshake state; registers return
// to window_length = min(16, DEPTH), trim_count = 2. The ring needs no clearing.
// ----------------------------------------------------------------------------
// trimmed_mean_window_filter
// Sliding window trimmed mean over a ring of ADC samples.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module trimmed_mean_window_filter #(
	parameter int DEPTH = tmwf_pkg::DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [tmwf_pkg::SAMPLE_W-1:0]   sample,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [tmwf_pkg::SAMPLE_W-1:0]   filtered_value,
	output logic                            too_few_samples,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tmwf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tmwf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tmwf_pkg::*;

	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW      = $clog2(DEPTH + 1);
	localparam int ACC_W   = SAMPLE_W + NW;
	localparam int WIN_DEF = (WIN_DEF_RAW < DEPTH) ? WIN_DEF_RAW : DEPTH;

	// sequencer codes
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_SORT = 3'd2;
	localparam logic [2:0] ST_SUM  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_RES  = 3'd5;

	logic [2:0]          state_q;
	logic [AW-1:0]       wp_q;
	logic [AW-1:0]       rptr_q;
	logic [NW-1:0]       fill_q;
	logic [NW-1:0]       n_q;
	logic [NW-1:0]       cnt_q;
	logic [NW-1:0]       hi_q;
	logic [NW-1:0]       kept_q;
	logic                rv_q;
	logic                par_q;
	logic [WL_W-1:0]     wl_q;
	logic [TRIM_W-1:0]   trim_q;
	logic [ACC_W-1:0]    sum_q;
	logic [SAMPLE_W-1:0] res_q;
	logic                few_q;
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] out_val_q;
	logic                out_few_q;

	logic [SAMPLE_W-1:0] store [DEPTH];
	logic [SAMPLE_W-1:0] rdata_q;
	logic [SAMPLE_W-1:0] win_q [DEPTH];

	logic                accept;
	logic                issue;
	logic                div_start;
	logic                div_done;
	logic [SAMPLE_W-1:0] div_quo;
	logic [NW-1:0]       fill_nx;
	logic [7:0]          n_pick;
	logic [NW-1:0]       n_nx;
	logic                few_nx;
	logic                out_free;
	logic [WL_W-1:0]     wl_in;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign issue    = (state_q == ST_LOAD) && (cnt_q != n_q);
	assign out_free = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;

	// Fill count saturates at DEPTH; window is the newest min(fill, window) samples.
	assign fill_nx = (fill_q == NW'(DEPTH)) ? fill_q : fill_q + NW'(1);
	assign n_pick  = (8'(fill_nx) < 8'(wl_q)) ? 8'(fill_nx) : 8'(wl_q);
	assign n_nx    = NW'(n_pick);
	assign few_nx  = {2'b00, trim_q, 1'b0} >= 9'(n_nx);

	// Out of range window lengths fall back to the default.
	assign wl_in = cfg_data[WL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q   <= WL_W'(WIN_DEF);
			trim_q <= TRIM_W'(TRIM_DEF);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WINDOW: begin
					if (wl_in == '0 || int'(wl_in) > DEPTH)
						wl_q <= WL_W'(WIN_DEF);
					else
						wl_q <= wl_in;
				end
				REG_TRIM: trim_q <= cfg_data[TRIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Ring store: written on accept, read one word per cycle while loading.
	always_ff @(posedge clk) begin
		if (accept)
			store[wp_q] <= sample;
		rdata_q <= store[rptr_q];
	end

	// Main sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_q        <= '0;
			rptr_q      <= '0;
			fill_q      <= '0;
			n_q         <= '0;
			cnt_q       <= '0;
			rv_q        <= 1'b0;
			par_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rv_q <= issue;
			// a new result in ST_RES takes over the output register itself
			if (out_valid_q && out_ready && state_q != ST_RES)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						wp_q   <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
						rptr_q <= wp_q;
						fill_q <= fill_nx;
						n_q    <= n_nx;
						cnt_q  <= '0;
						state_q <= few_nx ? ST_RES : ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (issue) begin
						cnt_q  <= cnt_q + NW'(1);
						rptr_q <= (rptr_q == '0) ? AW'(DEPTH - 1) : rptr_q - AW'(1);
					end else if (!rv_q) begin
						cnt_q   <= '0;
						par_q   <= 1'b0;
						state_q <= ST_SORT;
					end
				end
				ST_SORT: begin
					// n odd-even transposition passes sort the n live lanes
					par_q <= !par_q;
					if (cnt_q == n_q - NW'(1)) begin
						cnt_q   <= '0;
						state_q <= ST_SUM;
					end else begin
						cnt_q <= cnt_q + NW'(1);
					end
				end
				ST_SUM: begin
					if (cnt_q == n_q - NW'(1))
						state_q <= ST_DIV;
					cnt_q <= cnt_q + NW'(1);
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_RES;
				end
				ST_RES: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Window lanes: padded with all-ones, shifted in, sorted, shifted out.
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < DEPTH; k++)
				win_q[k] <= '1;
		end else if (state_q == ST_LOAD && rv_q) begin
			win_q[0] <= rdata_q;
			for (int k = 1; k < DEPTH; k++)
				win_q[k] <= win_q[k-1];
		end else if (state_q == ST_SORT) begin
			for (int k = 0; k < DEPTH - 1; k++) begin
				if (((k % 2) == 1) == par_q && win_q[k] > win_q[k+1]) begin
					win_q[k]   <= win_q[k+1];
					win_q[k+1] <= win_q[k];
				end
			end
		end else if (state_q == ST_SUM) begin
			for (int k = 0; k < DEPTH - 1; k++)
				win_q[k] <= win_q[k+1];
		end
	end

	// Sum of ranks trim..n-trim-1, then result capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			sum_q  <= '0;
			few_q  <= few_nx;
			res_q  <= '0;
			hi_q   <= n_nx - NW'(trim_q);
			kept_q <= n_nx - NW'({trim_q, 1'b0});
		end else if (state_q == ST_SUM) begin
			if (cnt_q >= NW'(trim_q) && cnt_q < hi_q)
				sum_q <= sum_q + ACC_W'(win_q[0]);
		end else if (state_q == ST_DIV && div_done) begin
			res_q <= div_quo;
		end
		if (state_q == ST_RES && out_free) begin
			out_val_q <= res_q;
			out_few_q <= few_q;
		end
	end

	assign div_start = (state_q == ST_SUM) && (cnt_q == n_q - NW'(1));

	tmwf_div #(
		.ACC_W (ACC_W),
		.NW    (NW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q + ((cnt_q >= NW'(trim_q) && cnt_q < hi_q) ?
		            ACC_W'(win_q[0]) : ACC_W'(0))),
		.divisor  (kept_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign out_valid       = out_valid_q;
	assign filtered_value  = out_val_q;
	assign too_few_samples = out_few_q;

	`ASSERT_CLK(a_accept_leaves_idle, clk, arst_n, accept |=> state_q != ST_IDLE)
	`ASSERT_NEVER(a_fill_bound, clk, arst_n, fill_q > NW'(DEPTH))
	`ASSERT_CLK(a_div_done_in_div, clk, arst_n, div_done |-> state_q == ST_DIV)
	`ASSERT_NEVER(a_read_outside_load, clk, arst_n, rv_q && state_q != ST_LOAD)

endmodule

/* rtl/tmwf_div.sv */
// ----------------------------------------------------------------------------
// tmwf_div
// Restoring divider, one quotient bit per cycle, done pulses once the last bit is in.
// ----------------------------------------------------------------------------
module tmwf_div #(
	parameter int ACC_W = 24,
	parameter int NW    = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ACC_W-1:0]              dividend,
	input  logic [NW-1:0]                 divisor,
	output logic                          done,
	output logic [tmwf_pkg::SAMPLE_W-1:0] quotient
);
	import tmwf_pkg::*;

	localparam int CNT_W = $clog2(ACC_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NW-1:0]    rem_q;
	logic [NW-1:0]    dvs_q;
	logic [ACC_W-1:0] quo_q;
	logic [NW:0]      shifted;
	logic             fits;

	assign shifted = {rem_q, quo_q[ACC_W-1]};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ACC_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? NW'(shifted - {1'b0, dvs_q}) : shifted[NW-1:0];
			quo_q <= {quo_q[ACC_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q[SAMPLE_W-1:0];

endmodule
